/* hw/rtl/mts_pkg.sv */
// Shared types, constants and conversion helpers for the minimum-tracking stack.
`default_nettype none

package mts_pkg;

  // Capacity of the stack and the width of one stored value.
  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;

  // Widths that follow from the capacity.
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Fixed port widths.
  localparam int PORT_W  = 32;
  localparam int COUNT_W = 5;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic signed [PORT_W-1:0]      port_t;
  typedef logic [ADDR_W-1:0]             addr_t;
  typedef logic [CNT_W-1:0]              cnt_t;

  // Operation codes; the unused code behaves as a peek.
  typedef enum logic [1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_PEEK = 2'd2
  } mode_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Bring a port value to the stored width (sign-extends or truncates).
  function automatic value_t narrow(port_t v);
    return value_t'(v);
  endfunction

  // Bring a stored value to the port width (sign-extends or truncates).
  function automatic port_t widen(value_t v);
    return port_t'(v);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/mts_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module mts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* hw/rtl/min_tracking_stack.sv */
// Top level of the minimum-tracking stack: sequencer, fill count and result register.
`default_nettype none

// A bounded stack of signed values that reports, after every operation, the top value,
// the minimum of all stored values, an empty flag, the entry count and a status. An
// operation is taken when start is high and busy is low; its result appears on the
// result ports for exactly one cycle, marked by done_o, and the receiver cannot stall it.
// Push, peek and any rejected operation report from the execute state; a pop that leaves
// entries behind passes through a further pop state, because the new top entry has to be
// read back from the value and minimum memories, whose read ports are registered.
// Every operation first reads the current top entry at the accepting edge.
// busy falls in the cycle that done_o is high, so a new operation can be taken there,
// but not before the last one has finished. A push on a full stack and a pop on an empty
// one leave the stack unchanged and report a status code; top and minimum read zero when
// the stack is empty. The memories need no clearing after reset: only entries below the
// fill count are ever used.

module min_tracking_stack (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         mode_i,
  input  wire logic signed [31:0] value_i,
  output logic                    done_o,
  output logic signed [31:0]      top_value_o,
  output logic signed [31:0]      min_value_o,
  output logic                    is_empty_o,
  output logic [4:0]              count_o,
  output logic [1:0]              status_o
);

  // One-hot sequencer states.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_POP  = 3'b100
  } state_e;

  state_e             state_q, state_d;
  mts_pkg::cnt_t      fill_q, fill_d;
  mts_pkg::mode_e     mode_q;
  mts_pkg::value_t    val_q;

  logic               done_q;
  mts_pkg::port_t     top_q, min_q;
  logic               empty_q;
  logic [mts_pkg::COUNT_W-1:0] count_q;
  mts_pkg::status_e   status_q;

  logic               accept;
  mts_pkg::cnt_t      fill_dec1, fill_dec2;
  logic               stack_empty, stack_full;

  logic               wr_en;
  mts_pkg::addr_t     wr_addr, rd_addr;
  mts_pkg::value_t    wr_min;
  mts_pkg::value_t    val_rdata, min_rdata;

  logic               res_load;
  mts_pkg::value_t    res_top, res_min;
  mts_pkg::status_e   res_status;
  logic               res_empty;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign fill_dec1   = fill_q - mts_pkg::cnt_t'(1);
  assign fill_dec2   = fill_q - mts_pkg::cnt_t'(2);
  assign stack_empty = (fill_q == '0);
  assign stack_full  = (fill_q == mts_pkg::cnt_t'(mts_pkg::DEPTH));

  // Read address: the current top on accept, the entry below it when a pop proceeds.
  always_comb begin
    if (state_q == S_EXEC) begin
      rd_addr = fill_dec2[mts_pkg::ADDR_W-1:0];
    end else begin
      rd_addr = fill_dec1[mts_pkg::ADDR_W-1:0];
    end
  end

  // Running minimum for a push: the value itself on an empty stack, else the smaller.
  always_comb begin
    if (!stack_empty && !(val_q < min_rdata)) begin
      wr_min = min_rdata;
    end else begin
      wr_min = val_q;
    end
  end

  assign wr_addr = fill_q[mts_pkg::ADDR_W-1:0];

  // Sequencer and result selection.
  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    wr_en      = 1'b0;
    res_load   = 1'b0;
    res_top    = val_rdata;
    res_min    = min_rdata;
    res_status = mts_pkg::ST_OK;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d  = S_IDLE;
        res_load = 1'b1;
        case (mode_q)
          mts_pkg::MODE_PUSH: begin
            if (stack_full) begin
              res_status = mts_pkg::ST_FULL;
            end else begin
              wr_en   = 1'b1;
              fill_d  = fill_q + mts_pkg::cnt_t'(1);
              res_top = val_q;
              res_min = wr_min;
            end
          end
          mts_pkg::MODE_POP: begin
            if (stack_empty) begin
              res_status = mts_pkg::ST_EMPTY;
            end else begin
              fill_d = fill_dec1;
              // Entries remain: fetch the new top before reporting.
              if (fill_dec1 != '0) begin
                state_d  = S_POP;
                res_load = 1'b0;
              end
            end
          end
          default: begin
          end
        endcase
      end
      S_POP: begin
        state_d  = S_IDLE;
        res_load = 1'b1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_empty = (fill_d == '0);

  // Value and running-minimum memories.
  mts_ram #(
    .WIDTH (mts_pkg::VALUE_WIDTH),
    .DEPTH (mts_pkg::DEPTH)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (val_q),
    .raddr_i (rd_addr),
    .rdata_o (val_rdata)
  );

  mts_ram #(
    .WIDTH (mts_pkg::VALUE_WIDTH),
    .DEPTH (mts_pkg::DEPTH)
  ) u_min_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_min),
    .raddr_i (rd_addr),
    .rdata_o (min_rdata)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      done_q  <= res_load;
    end
  end

  // Captured operation.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mts_pkg::mode_e'(mode_i);
      val_q  <= mts_pkg::narrow(value_i);
    end
  end

  // Result register; top and minimum read zero on an empty stack.
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      top_q    <= res_empty ? '0 : mts_pkg::widen(res_top);
      min_q    <= res_empty ? '0 : mts_pkg::widen(res_min);
      empty_q  <= res_empty;
      count_q  <= mts_pkg::COUNT_W'(fill_d);
      status_q <= res_status;
    end
  end

  assign done_o      = done_q;
  assign top_value_o = top_q;
  assign min_value_o = min_q;
  assign is_empty_o  = empty_q;
  assign count_o     = count_q;
  assign status_o    = status_q;

  // The sequencer is back in idle whenever a result beat is presented.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result beat while the sequencer is still busy");

  // An accepted operation holds the block busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> busy)
    else $error("accepted operation did not make the block busy");

  // The fill count never exceeds the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= mts_pkg::cnt_t'(mts_pkg::DEPTH))
    else $error("fill count beyond capacity");

  // A rejected push is only reported on a full stack.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == mts_pkg::ST_FULL) |->
      (fill_q == mts_pkg::cnt_t'(mts_pkg::DEPTH)))
    else $error("push rejected although the stack is not full");

  // An empty result reports zero for top and minimum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && is_empty_o) |-> (top_value_o == '0 && min_value_o == '0))
    else $error("empty result with non-zero top or minimum");

endmodule

`default_nettype wire
